[rtl/one_rule_classifier_trainer_core_macros.svh]
// assertion macros for the classifier trainer rtl, included by orc_back
// no dependencies, included inside module bodies that assert
`ifndef ONE_RULE_CLASSIFIER_TRAINER_CORE_MACROS_SVH
`define ONE_RULE_CLASSIFIER_TRAINER_CORE_MACROS_SVH

// same-cycle implication
`define ORC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orc assertion failed");

// next-cycle implication
`define ORC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("orc assertion failed");

`endif

[rtl/orc_pkg.sv]
// package for the one-rule classifier trainer: beat types, codes, fsm states
// no dependencies
package orc_pkg;

    localparam int CODE_W  = 4;
    localparam int ATTR_N  = 8;
    localparam int ATTR_W  = 3;
    localparam int TOTAL_W = 16;

    typedef struct packed {
        logic [CODE_W-1:0] attr0;
        logic [CODE_W-1:0] attr1;
        logic [CODE_W-1:0] attr2;
        logic [CODE_W-1:0] attr3;
        logic [CODE_W-1:0] attr4;
        logic [CODE_W-1:0] attr5;
        logic [CODE_W-1:0] attr6;
        logic [CODE_W-1:0] attr7;
        logic [CODE_W-1:0] class_code;
        logic              last;
    } in_t;

    typedef struct packed {
        logic [ATTR_W-1:0]  best_attribute;
        logic [CODE_W-1:0]  value_code;
        logic [CODE_W-1:0]  predicted_class;
        logic [TOTAL_W-1:0] error_count;
        logic [TOTAL_W-1:0] instance_total;
        logic               is_rule;
        logic               final_item;
    } out_t;

    typedef struct packed {
        logic [ATTR_N-1:0][CODE_W-1:0] vals;
        logic [CODE_W-1:0]             cls;
        logic [ATTR_N-1:0]             en;
        logic                          last;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_WR,
        ST_EVAL,
        ST_EVAL_WAIT,
        ST_PICK,
        ST_RULE,
        ST_RULE_WAIT,
        ST_RULE_CHK,
        ST_SUMMARY
    } state_t;

endpackage

[rtl/one_rule_classifier_trainer_core.sv]
// top level of the one-rule classifier trainer
// depends on orc_pkg, orc_front, orc_back (and orc_ram through orc_back)
//
//  channel  | handshake              | beat
//  ---------+------------------------+-------------------------
//  in       | in_valid / in_ready    | orc_pkg::in_t instance
//  out      | out_valid / out_ready  | orc_pkg::out_t rule or summary
//  cfg      | cfg_wr_en              | attribute count, 4 bits
//
// an instance passes the counting unit as a bank read, then a write back
// a last instance adds table walks (evaluation, attribute pick, one rule walk per value
// code below VALUE_CODES-1), then a clear sweep over all 2^(VB+CB) entries (256 at default)
// after reset the same clear sweep runs with in_ready low
// a two-beat command queue takes input while the back end is busy or stalled, until it fills
module one_rule_classifier_trainer_core #(
    parameter int MAX_ATTRS   = 8,
    parameter int VALUE_CODES = 16,
    parameter int CLASS_CODES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  orc_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output orc_pkg::out_t              out_data,
    input  logic                       cfg_wr_en,
    input  logic [orc_pkg::CODE_W-1:0] cfg_wr_data
);
    import orc_pkg::*;

    logic q_valid;
    cmd_t q_data;
    logic q_pop;
    logic init_busy;

    orc_front #(
        .MAX_ATTRS   (MAX_ATTRS),
        .VALUE_CODES (VALUE_CODES),
        .CLASS_CODES (CLASS_CODES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .init_busy   (init_busy),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop)
    );

    orc_back #(
        .MAX_ATTRS   (MAX_ATTRS),
        .VALUE_CODES (VALUE_CODES),
        .CLASS_CODES (CLASS_CODES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/orc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module orc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/orc_front.sv]
// front end: attribute count register, code folding, two-entry command queue
// depends on orc_pkg
module orc_front #(
    parameter int MAX_ATTRS   = 8,
    parameter int VALUE_CODES = 16,
    parameter int CLASS_CODES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  orc_pkg::in_t                  in_data,
    input  logic                          cfg_wr_en,
    input  logic [orc_pkg::CODE_W-1:0]    cfg_wr_data,
    input  logic                          init_busy,
    output logic                          q_valid,
    output orc_pkg::cmd_t                 q_data,
    input  logic                          q_pop
);
    import orc_pkg::*;

    localparam logic [CODE_W-1:0] VAL_MISS = CODE_W'(VALUE_CODES - 1);
    localparam logic [CODE_W-1:0] CLS_MISS = CODE_W'(CLASS_CODES - 1);
    localparam logic [CODE_W-1:0] MAX_N    = CODE_W'(MAX_ATTRS);

    logic [CODE_W-1:0]             attr_cnt_reg;
    logic [ATTR_N-1:0][CODE_W-1:0] raw;
    logic [CODE_W-1:0]             n_use;
    cmd_t                          cmd;
    cmd_t                          q_reg [0:1];
    logic                          wr_ptr_reg, wr_ptr_next;
    logic                          rd_ptr_reg, rd_ptr_next;
    logic [1:0]                    fill_reg, fill_next;
    logic                          push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_cnt_reg <= CODE_W'(8);
        end
        else if (cfg_wr_en)
        begin
            attr_cnt_reg <= cfg_wr_data;
        end
    end

    assign raw = {in_data.attr7, in_data.attr6, in_data.attr5, in_data.attr4,
                  in_data.attr3, in_data.attr2, in_data.attr1, in_data.attr0};

    always_comb
    begin
        if (attr_cnt_reg == '0)
        begin
            n_use = CODE_W'(1);
        end
        else if (attr_cnt_reg > MAX_N)
        begin
            n_use = MAX_N;
        end
        else
        begin
            n_use = attr_cnt_reg;
        end
        for (int i = 0; i < ATTR_N; i++)
        begin
            cmd.vals[i] = (raw[i] >= VAL_MISS) ? VAL_MISS : raw[i];
            cmd.en[i]   = (CODE_W'(i) < n_use) && (i < MAX_ATTRS);
        end
        cmd.cls  = (in_data.class_code >= CLS_MISS) ? CLS_MISS : in_data.class_code;
        cmd.last = in_data.last;
    end

    assign in_ready = (fill_reg != 2'd2) && !init_busy;
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_data   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[rtl/orc_back.sv]
// back end: per-attribute count banks, evaluation walk, rule emission, clear sweep
// depends on orc_pkg, orc_ram and the assertion macro header
module orc_back #(
    parameter int MAX_ATTRS   = 8,
    parameter int VALUE_CODES = 16,
    parameter int CLASS_CODES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  orc_pkg::cmd_t  q_data,
    output logic           q_pop,
    output logic           init_busy,
    output logic           out_valid,
    input  logic           out_ready,
    output orc_pkg::out_t  out_data
);
    import orc_pkg::*;
    `include "one_rule_classifier_trainer_core_macros.svh"

    localparam int VB    = (VALUE_CODES > 1) ? $clog2(VALUE_CODES) : 1;
    localparam int CB    = (CLASS_CODES > 1) ? $clog2(CLASS_CODES) : 1;
    localparam int AW    = VB + CB;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = COUNT_BITS + CB;
    localparam int EW    = COUNT_BITS + AW;
    localparam logic [VB-1:0] LAST_RULE_V = VB'(VALUE_CODES - 2);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [VB-1:0]         rv_reg, rv_next;
    logic [ATTR_W-1:0]     lane_reg, lane_next;
    logic [ATTR_W-1:0]     chosen_reg, chosen_next;
    logic [EW-1:0]         best_err_reg, best_err_next;
    logic [TOTAL_W-1:0]    inst_reg, inst_next;
    logic                  init_reg, init_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [CB-1:0]         rd_c_reg, rd_c_next;
    logic                  eval_mode;
    logic                  clr_err;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;

    logic [AW-1:0]         raddr [0:MAX_ATTRS-1];
    logic [AW-1:0]         waddr [0:MAX_ATTRS-1];
    logic [COUNT_BITS-1:0] rdata [0:MAX_ATTRS-1];
    logic [COUNT_BITS-1:0] wdata [0:MAX_ATTRS-1];
    logic [MAX_ATTRS-1:0]  we;

    logic [COUNT_BITS-1:0] best_reg [0:MAX_ATTRS-1];
    logic [COUNT_BITS-1:0] best_n   [0:MAX_ATTRS-1];
    logic [SW-1:0]         sum_reg  [0:MAX_ATTRS-1];
    logic [SW-1:0]         sum_n    [0:MAX_ATTRS-1];
    logic [CB-1:0]         bc_reg   [0:MAX_ATTRS-1];
    logic [CB-1:0]         bc_n     [0:MAX_ATTRS-1];
    logic [EW-1:0]         err_reg  [0:MAX_ATTRS-1];
    logic [EW-1:0]         err_n    [0:MAX_ATTRS-1];
    logic [TOTAL_W-1:0]    err_sat;

    for (genvar l = 0; l < MAX_ATTRS; l++)
    begin : g_bank
        orc_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we[l]),
            .waddr (waddr[l]),
            .wdata (wdata[l]),
            .raddr (raddr[l]),
            .rdata (rdata[l])
        );
    end

    // per-lane argmax and error accumulation on returning read data
    always_comb
    begin
        for (int l = 0; l < MAX_ATTRS; l++)
        begin
            best_n[l] = best_reg[l];
            sum_n[l]  = sum_reg[l];
            bc_n[l]   = bc_reg[l];
            err_n[l]  = clr_err ? '0 : err_reg[l];
            if (rd_valid_reg)
            begin
                if (rd_c_reg == '0)
                begin
                    best_n[l] = rdata[l];
                    bc_n[l]   = '0;
                    sum_n[l]  = SW'(rdata[l]);
                end
                else
                begin
                    if (rdata[l] > best_reg[l])
                    begin
                        best_n[l] = rdata[l];
                        bc_n[l]   = rd_c_reg;
                    end
                    sum_n[l] = sum_reg[l] + SW'(rdata[l]);
                end
                if (eval_mode && (rd_c_reg == '1))
                begin
                    err_n[l] = err_reg[l] + EW'(sum_n[l] - SW'(best_n[l]));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < MAX_ATTRS; l++)
        begin
            best_reg[l] <= best_n[l];
            sum_reg[l]  <= sum_n[l];
            bc_reg[l]   <= bc_n[l];
            err_reg[l]  <= err_n[l];
        end
        cmd_reg      <= cmd_next;
        out_reg      <= out_next;
        best_err_reg <= best_err_next;
        rd_c_reg     <= rd_c_next;
    end

    assign err_sat = ({16'd0, best_err_reg} > (EW + 16)'(16'hFFFF))
                     ? 16'hFFFF : best_err_reg[TOTAL_W-1:0];
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        rv_next        = rv_reg;
        lane_next      = lane_reg;
        chosen_next    = chosen_reg;
        best_err_next  = best_err_reg;
        inst_next      = inst_reg;
        init_next      = init_reg;
        rd_valid_next  = 1'b0;
        rd_c_next      = rd_c_reg;
        eval_mode      = (state_reg == ST_EVAL) || (state_reg == ST_EVAL_WAIT);
        clr_err        = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        we             = '0;
        for (int l = 0; l < MAX_ATTRS; l++)
        begin
            raddr[l] = ptr_reg;
            waddr[l] = ptr_reg;
            wdata[l] = '0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we       = '1;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == '1)
                begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                for (int l = 0; l < MAX_ATTRS; l++)
                begin
                    raddr[l] = {q_data.vals[l][VB-1:0], q_data.cls[CB-1:0]};
                end
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = ST_CNT_WR;
                end
            end
            ST_CNT_WR:
            begin
                for (int l = 0; l < MAX_ATTRS; l++)
                begin
                    wdata[l] = (rdata[l] == CNT_MAX) ? rdata[l]
                               : rdata[l] + COUNT_BITS'(1);
                    we[l]    = cmd_reg.en[l];
                    waddr[l] = {cmd_reg.vals[l][VB-1:0], cmd_reg.cls[CB-1:0]};
                end
                if (inst_reg != '1)
                begin
                    inst_next = inst_reg + TOTAL_W'(1);
                end
                if (cmd_reg.last)
                begin
                    clr_err    = 1'b1;
                    ptr_next   = '0;
                    state_next = ST_EVAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                rd_valid_next = 1'b1;
                rd_c_next     = ptr_reg[CB-1:0];
                ptr_next      = ptr_reg + AW'(1);
                if (ptr_reg == '1)
                begin
                    state_next = ST_EVAL_WAIT;
                end
            end
            ST_EVAL_WAIT:
            begin
                lane_next  = '0;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (cmd_reg.en[lane_reg] &&
                    ((lane_reg == '0) || (err_reg[lane_reg] < best_err_reg)))
                begin
                    best_err_next = err_reg[lane_reg];
                    chosen_next   = lane_reg;
                end
                lane_next = lane_reg + ATTR_W'(1);
                if (lane_reg == ATTR_W'(MAX_ATTRS - 1))
                begin
                    rv_next    = '0;
                    ptr_next   = '0;
                    state_next = ST_RULE;
                end
            end
            ST_RULE:
            begin
                for (int l = 0; l < MAX_ATTRS; l++)
                begin
                    raddr[l] = {rv_reg, ptr_reg[CB-1:0]};
                end
                rd_valid_next = 1'b1;
                rd_c_next     = ptr_reg[CB-1:0];
                ptr_next      = ptr_reg + AW'(1);
                if (ptr_reg[CB-1:0] == '1)
                begin
                    state_next = ST_RULE_WAIT;
                end
            end
            ST_RULE_WAIT:
            begin
                state_next = ST_RULE_CHK;
            end
            ST_RULE_CHK:
            begin
                if ((sum_reg[chosen_reg] == '0) || slot_free)
                begin
                    if (sum_reg[chosen_reg] != '0)
                    begin
                        out_valid_next          = 1'b1;
                        out_next.best_attribute = chosen_reg;
                        out_next.value_code     = CODE_W'(rv_reg);
                        out_next.predicted_class = CODE_W'(bc_reg[chosen_reg]);
                        out_next.error_count    = err_sat;
                        out_next.instance_total = inst_reg;
                        out_next.is_rule        = 1'b1;
                        out_next.final_item     = 1'b0;
                    end
                    ptr_next = '0;
                    if (rv_reg == LAST_RULE_V)
                    begin
                        state_next = ST_SUMMARY;
                    end
                    else
                    begin
                        rv_next    = rv_reg + VB'(1);
                        state_next = ST_RULE;
                    end
                end
            end
            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.best_attribute  = chosen_reg;
                    out_next.value_code      = '0;
                    out_next.predicted_class = '0;
                    out_next.error_count     = err_sat;
                    out_next.instance_total  = inst_reg;
                    out_next.is_rule         = 1'b0;
                    out_next.final_item      = 1'b1;
                    inst_next                = '0;
                    ptr_next                 = '0;
                    state_next               = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            rv_reg        <= '0;
            lane_reg      <= '0;
            chosen_reg    <= '0;
            inst_reg      <= '0;
            init_reg      <= 1'b1;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rv_reg        <= rv_next;
            lane_reg      <= lane_next;
            chosen_reg    <= chosen_next;
            inst_reg      <= inst_next;
            init_reg      <= init_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign init_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ORC_ASSERT_NOW(a_no_pop_busy, state_reg != ST_IDLE, !q_pop)
    `ORC_ASSERT_NEXT(a_pop_then_count, q_pop, state_reg == ST_CNT_WR)
    `ORC_ASSERT_NOW(a_summary_flags, out_valid_reg && out_reg.final_item, !out_reg.is_rule)
    `ORC_ASSERT_NOW(a_init_only_clear, init_reg, state_reg == ST_CLEAR)

endmodule

[dv/one_rule_classifier_trainer_core_tb.sv]
// testbench for the one-rule classifier trainer core: directed and random training sets
// depends on orc_pkg and the one_rule_classifier_trainer_core rtl
`timescale 1ns / 100ps

module one_rule_classifier_trainer_core_tb;
    import orc_pkg::*;

    localparam int VALUES = 16;
    localparam int CLASSES = 16;
    localparam int MISS = 15;
    localparam int COUNT_TOP = 65535;
    localparam int HOLD_LEN = 600;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_wr_en;
    logic [CODE_W-1:0] cfg_wr_data;

    one_rule_classifier_trainer_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    int tally [ATTR_N][VALUES][CLASSES];
    int seen_count;
    logic [3:0] attr_setting;
    out_t rule_queue [$];
    int errors = 0;
    longint cycles = 0;
    bit quiet_mode;
    bit hold_req;
    bit hold_taken;
    int hold_cycles;

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int attrs_used();
        int n;
        n = attr_setting;
        if (n < 1) n = 1;
        if (n > ATTR_N) n = ATTR_N;
        return n;
    endfunction

    function automatic int pick_class(int a, int v, output int cls, output int sum);
        int top;
        top = 0;
        cls = 0;
        sum = 0;
        for (int c = 0; c < CLASSES; c++) begin
            if (tally[a][v][c] > top) begin
                top = tally[a][v][c];
                cls = c;
            end
            sum += tally[a][v][c];
        end
        return sum - top;
    endfunction

    task automatic train_on(in_t it);
        int n;
        int c;
        int v;
        int best;
        int chosen;
        int e;
        int cls;
        int sum;
        logic [3:0] codes [ATTR_N];
        out_t r;
        n = attrs_used();
        codes = '{it.attr0, it.attr1, it.attr2, it.attr3, it.attr4, it.attr5, it.attr6,
                  it.attr7};
        c = it.class_code;
        for (int a = 0; a < n; a++) begin
            v = codes[a];
            if (tally[a][v][c] < COUNT_TOP) tally[a][v][c]++;
        end
        if (seen_count < COUNT_TOP) seen_count++;
        if (!it.last) return;
        best = 0;
        chosen = 0;
        for (int a = 0; a < n; a++) begin
            e = 0;
            for (int vv = 0; vv < VALUES; vv++) e += pick_class(a, vv, cls, sum);
            if (a == 0 || e < best) begin
                best = e;
                chosen = a;
            end
        end
        if (best > COUNT_TOP) best = COUNT_TOP;
        r.best_attribute = 3'(chosen);
        r.error_count = 16'(best);
        r.instance_total = 16'(seen_count);
        for (int vv = 0; vv < MISS; vv++) begin
            void'(pick_class(chosen, vv, cls, sum));
            if (sum != 0) begin
                r.value_code = 4'(vv);
                r.predicted_class = 4'(cls);
                r.is_rule = 1'b1;
                r.final_item = 1'b0;
                rule_queue = {rule_queue, r};
            end
        end
        r.value_code = 4'd0;
        r.predicted_class = 4'd0;
        r.is_rule = 1'b0;
        r.final_item = 1'b1;
        rule_queue = {rule_queue, r};
        tally = '{default: '{default: '{default: 0}}};
        seen_count = 0;
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (rule_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %p", out_data);
            end else begin
                if (out_data !== rule_queue[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %p got %p", rule_queue[0], out_data);
                end
                void'(rule_queue.pop_front());
            end
        end
    end

    // receiver with random stalls and one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 0;
            hold_cycles <= 0;
            hold_taken <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1;
            hold_cycles <= HOLD_LEN;
            out_ready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 0;
        end else out_ready <= quiet_mode || ($urandom_range(99) >= 23);
    end

    task automatic send_beat(in_t it);
        while (!quiet_mode && $urandom_range(99) < 23) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        train_on(it);
    endtask

    function automatic in_t random_beat(bit last, int span);
        in_t it;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        it = noise[$bits(in_t)-1:0];
        it.attr0 = 4'($urandom_range(span));
        it.attr1 = 4'($urandom_range(span));
        it.attr2 = 4'($urandom_range(span));
        it.class_code = 4'($urandom_range(span));
        if ($urandom_range(9) == 0) it.attr0 = 4'(MISS);
        it.last = last;
        return it;
    endfunction

    task automatic drain();
        in_valid <= 0;
        while (rule_queue.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_setting(logic [3:0] val);
        cfg_wr_en <= 1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 0;
        attr_setting = val;
    endtask

    task automatic test_directed();
        in_t it;
        it = '0;
        send_beat(it);
        it = '1;
        send_beat(it);
        it = '0;
        it.class_code = 4'(MISS);
        it.attr1 = 4'd3;
        send_beat(it);
        it = '1;
        it.class_code = 4'd2;
        it.attr2 = 4'd0;
        it.last = 1;
        send_beat(it);
        // single-instance run
        it = '0;
        it.last = 1;
        send_beat(it);
        // all codes missing, so no rule beat comes out, only the summary
        it = '1;
        send_beat(it);
        drain();
    endtask

    task automatic test_settings();
        logic [3:0] sets [5];
        sets = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        foreach (sets[i]) begin
            write_setting(sets[i]);
            for (int k = 0; k < 4; k++) send_beat(random_beat(k == 3, 15));
            drain();
        end
    endtask

    task automatic test_random();
        int len;
        for (int s = 0; s < 50; s++) begin
            if (s == 20) quiet_mode = 1;
            if (s == 30) quiet_mode = 0;
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) send_beat(random_beat(k == len - 1,
                ($urandom_range(1) ? 3 : 15)));
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int s = 0; s < 6; s++)
            for (int k = 0; k < 3; k++) send_beat(random_beat(k == 2, 15));
        drain();
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        quiet_mode = 0;
        hold_req = 0;
        attr_setting = 4'd8;
        seen_count = 0;
        tally = '{default: '{default: '{default: 0}}};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_random();
        test_backpressure();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
